// File: rtl/lccp_pkg.sv
`timescale 1ns / 1ps
// Package for the lattice coefficient compress/pack unit.
// Holds widths, register codes, item and result types and the rounding helpers.
package lccp_pkg;

	localparam int LCCP_COEF_W     = 13;
	localparam int LCCP_BYTE_W     = 8;
	localparam int LCCP_VALUE_W    = 12;
	localparam int LCCP_ACC_W      = 16;
	localparam int LCCP_CNT_W      = 4;
	localparam int LCCP_T_W        = 6;
	localparam int LCCP_BITS_W     = 3;
	localparam int LCCP_CFG_DATA_W = 3;
	localparam int LCCP_CFG_IDX_W  = 1;
	localparam int LCCP_NUM_W      = 19;
	localparam int LCCP_PROD_W     = 38;
	localparam int LCCP_EXP_W      = 18;
	localparam int LCCP_FIFO_DEPTH = 4;

	localparam logic [11:0] LCCP_MODULUS    = 12'd3329;
	localparam logic [10:0] LCCP_ROUND_HALF = 11'd1664;
	// ceil(2^30 / 3329): exact floor division for every numerator below 2^19
	localparam logic [18:0] LCCP_RECIP       = 19'd322542;
	localparam int          LCCP_RECIP_SHIFT = 30;

	localparam logic [LCCP_BITS_W-1:0] LCCP_BITS_RESET = 3'd6;
	localparam logic [LCCP_BITS_W-1:0] LCCP_BITS_MIN   = 3'd4;
	localparam logic [LCCP_BITS_W-1:0] LCCP_BITS_MAX   = 3'd6;

	typedef enum logic [LCCP_CFG_IDX_W-1:0] {
		LCCP_REG_COMPRESS_BITS = 1'b0,
		LCCP_REG_DIRECTION     = 1'b1
	} lccp_reg_t;

	typedef enum logic {
		LCCP_DIR_COMPRESS   = 1'b0,
		LCCP_DIR_DECOMPRESS = 1'b1
	} lccp_dir_t;

	typedef struct packed {
		logic signed [LCCP_COEF_W-1:0] coefficient;
		logic [LCCP_BYTE_W-1:0]        in_byte;
		logic                          end_of_poly;
	} lccp_item_t;

	typedef struct packed {
		logic [LCCP_VALUE_W-1:0] value;
		logic                    last;
	} lccp_result_t;

	typedef struct packed {
		logic [1:0]   n;
		lccp_result_t res0;
		lccp_result_t res1;
	} lccp_push_t;

	typedef struct packed {
		logic [LCCP_ACC_W-1:0] acc;
		logic [LCCP_CNT_W-1:0] cnt;
	} lccp_state_t;

	function automatic logic [LCCP_BITS_W-1:0] lccp_width(logic [LCCP_BITS_W-1:0] bits);
		if (bits < LCCP_BITS_MIN) return LCCP_BITS_MIN;
		if (bits > LCCP_BITS_MAX) return LCCP_BITS_MAX;
		return bits;
	endfunction

	function automatic logic [LCCP_T_W-1:0] lccp_mask(logic [LCCP_BITS_W-1:0] d);
		case (d)
			3'd4:    return 6'h0f;
			3'd5:    return 6'h1f;
			default: return 6'h3f;
		endcase
	endfunction

	function automatic logic [LCCP_VALUE_W-1:0] lccp_expand(logic [LCCP_T_W-1:0] t,
			logic [LCCP_BITS_W-1:0] d);
		logic [LCCP_EXP_W-1:0] prod;
		prod = LCCP_EXP_W'(t) * LCCP_EXP_W'(LCCP_MODULUS)
			+ (LCCP_EXP_W'(1) << (d - 3'd1));
		return LCCP_VALUE_W'(prod >> d);
	endfunction

endpackage

// File: rtl/lccp_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for items and results.
// Depends on lccp_pkg for field widths.
interface lccp_in_if import lccp_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [LCCP_COEF_W-1:0] coefficient;
	logic [LCCP_BYTE_W-1:0]        in_byte;
	logic                          end_of_poly;

	modport source(output valid, coefficient, in_byte, end_of_poly, input ready);
	modport sink(input valid, coefficient, in_byte, end_of_poly, output ready);
endinterface

interface lccp_out_if import lccp_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [LCCP_VALUE_W-1:0] out_value;
	logic                    last;

	modport source(output valid, out_value, last, input ready);
	modport sink(input valid, out_value, last, output ready);
endinterface

// File: rtl/lccp_codec.sv
`timescale 1ns / 1ps
// Single-pass codec datapath: rounding, packing and unpacking for one item.
// Depends on lccp_pkg.
module lccp_codec import lccp_pkg::*; (
	input  lccp_dir_t              direction,
	input  logic [LCCP_BITS_W-1:0] d,
	input  lccp_item_t             item,
	input  lccp_state_t            state,
	output lccp_push_t             push,
	output lccp_state_t            state_next
);

	logic signed [LCCP_COEF_W+1:0] vs_s;
	logic [LCCP_COEF_W-1:0]        vs;
	logic [LCCP_NUM_W-1:0]         num;
	logic [LCCP_PROD_W-1:0]        prod;
	logic [LCCP_T_W-1:0]           mask;
	logic [LCCP_T_W-1:0]           t;
	logic [LCCP_CNT_W-1:0]         d_cnt;

	assign mask  = lccp_mask(d);
	assign d_cnt = LCCP_CNT_W'(d);

	// normalise to a non-negative value, then round by reciprocal multiply
	assign vs_s = (LCCP_COEF_W+2)'(item.coefficient) + (LCCP_COEF_W+2)'(LCCP_MODULUS)
		+ (item.coefficient[LCCP_COEF_W-1] ? (LCCP_COEF_W+2)'(LCCP_MODULUS)
		: (LCCP_COEF_W+2)'(0));
	assign vs   = vs_s[LCCP_COEF_W-1:0];
	assign num  = (LCCP_NUM_W'(vs) << d) + LCCP_NUM_W'(LCCP_ROUND_HALF);
	assign prod = LCCP_PROD_W'(num) * LCCP_PROD_W'(LCCP_RECIP);
	assign t    = prod[LCCP_RECIP_SHIFT +: LCCP_T_W] & mask;

	always_comb begin
		logic [LCCP_ACC_W-1:0] acc1;
		logic [LCCP_ACC_W-1:0] acc2;
		logic [LCCP_CNT_W-1:0] cnt1;
		logic [LCCP_CNT_W-1:0] cnt2;
		logic [LCCP_CNT_W-1:0] cnt3;
		push       = '0;
		state_next = state;
		acc1       = '0;
		acc2       = '0;
		cnt1       = '0;
		cnt2       = '0;
		cnt3       = '0;
		case (direction)
			LCCP_DIR_COMPRESS: begin
				acc1 = state.acc | (LCCP_ACC_W'(t) << state.cnt);
				cnt1 = state.cnt + d_cnt;
				acc2 = acc1;
				cnt2 = cnt1;
				if (cnt1 >= 4'd8) begin
					push.n          = 2'd1;
					push.res0.value = LCCP_VALUE_W'(acc1[7:0]);
					acc2            = acc1 >> 8;
					cnt2            = cnt1 - 4'd8;
				end
				// flush the partial byte at the end of the polynomial
				if (item.end_of_poly && cnt2 != '0) begin
					if (push.n == 2'd0) begin
						push.res0.value = LCCP_VALUE_W'(acc2[7:0]);
					end else begin
						push.res1.value = LCCP_VALUE_W'(acc2[7:0]);
					end
					push.n = push.n + 2'd1;
				end
				state_next.acc = acc2;
				state_next.cnt = cnt2;
			end
			LCCP_DIR_DECOMPRESS: begin
				acc1 = state.acc | (LCCP_ACC_W'(item.in_byte) << state.cnt[2:0]);
				cnt1 = state.cnt + 4'd8;
				state_next.acc = acc1;
				state_next.cnt = cnt1;
				if (cnt1 >= d_cnt) begin
					push.n          = 2'd1;
					push.res0.value = lccp_expand(acc1[LCCP_T_W-1:0] & mask, d);
					acc2            = acc1 >> d;
					cnt2            = cnt1 - d_cnt;
					state_next.acc  = acc2;
					state_next.cnt  = cnt2;
					if (cnt2 >= d_cnt) begin
						push.n          = 2'd2;
						push.res1.value = lccp_expand(acc2[LCCP_T_W-1:0] & mask, d);
						cnt3            = cnt2 - d_cnt;
						state_next.acc  = acc2 >> d;
						state_next.cnt  = cnt3;
					end
				end
			end
			default: begin
				push       = '0;
				state_next = state;
			end
		endcase
		if (item.end_of_poly) begin
			push.res0.last = (push.n == 2'd1);
			push.res1.last = (push.n == 2'd2);
			state_next     = '0;
		end
	end

endmodule

// File: rtl/lccp_result_fifo.sv
`timescale 1ns / 1ps
// Result queue: takes up to two results a cycle, hands out one a cycle while results.ready is high.
// Depends on lccp_pkg and lccp_if.
module lccp_result_fifo import lccp_pkg::*; #(
	parameter int DEPTH = LCCP_FIFO_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push_en,
	input  lccp_push_t push,
	output logic       room,
	lccp_out_if.source results
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int OCC_W = $clog2(DEPTH + 1);

	lccp_result_t     entry_q [DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [OCC_W-1:0] occ_q;
	logic             pop;
	logic [1:0]       n_in;

	assign n_in = push_en ? push.n : 2'd0;
	assign pop  = results.valid && results.ready;
	assign room = (occ_q <= OCC_W'(DEPTH - 2));

	assign results.valid     = (occ_q != '0);
	assign results.out_value = entry_q[rptr_q].value;
	assign results.last      = entry_q[rptr_q].last;

	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			if (n_in != 2'd0 && wptr_q == PTR_W'(i)) begin
				entry_q[i] <= push.res0;
			end else if (n_in == 2'd2 && PTR_W'(wptr_q + PTR_W'(1)) == PTR_W'(i)) begin
				entry_q[i] <= push.res1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			occ_q  <= '0;
		end else begin
			wptr_q <= wptr_q + PTR_W'(n_in);
			if (pop) begin
				rptr_q <= rptr_q + PTR_W'(1);
			end
			occ_q <= occ_q + OCC_W'(n_in) - OCC_W'(pop);
		end
	end

endmodule

// File: rtl/lattice_coeff_compress_pack_unit.sv
`timescale 1ns / 1ps
// Coefficient compress/pack and unpack/decompress unit, modulus 3329.
// Depends on lccp_pkg, lccp_if, lccp_codec and lccp_result_fifo.
//
// Usage:
//   items   : valid/ready channel carrying coefficient, in_byte and end_of_poly.
//   results : valid/ready channel carrying out_value and last.
//   cfg     : write port; index 0 sets compress_bits (4..6, clamped), index 1
//             sets direction (0 compress, 1 decompress). Every write clears the
//             bit accumulator. Write only while no transaction is in flight.
//   A transaction on items lands in the input stage; once the queue has room,
//   the codec turns it into zero, one or two results in a single pass and
//   writes them into a four-entry result queue.
//   Throughput: one item per cycle while each item yields at most one result and
//   results.ready stays high; the output port hands out one result per cycle, so
//   items that yield two results are limited by that port. items.ready stays high
//   while the queue has room for two more results.
//   When results.ready is held low the queue fills and items.ready drops; no
//   result is lost or repeated. Reset empties the input stage and the queue,
//   clears the accumulator and sets compress_bits to 6, direction to compress.
module lattice_coeff_compress_pack_unit import lccp_pkg::*; #(
	parameter int FIFO_DEPTH = LCCP_FIFO_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [LCCP_CFG_IDX_W-1:0]  cfg_index,
	input  logic [LCCP_CFG_DATA_W-1:0] cfg_data,
	lccp_in_if.sink                    items,
	lccp_out_if.source                 results
);

	logic                   valid_s1;
	lccp_item_t             item_s1;
	logic [LCCP_BITS_W-1:0] bits_q;
	lccp_dir_t              dir_q;
	lccp_state_t            state_q;
	lccp_state_t            state_next;
	lccp_push_t             push;
	logic                   room;
	logic                   consume;
	logic                   accept;

	assign consume     = valid_s1 && room;
	assign items.ready = !valid_s1 || room;
	assign accept      = items.valid && items.ready;

	lccp_codec u_codec (
		.direction (dir_q),
		.d         (lccp_width(bits_q)),
		.item      (item_s1),
		.state     (state_q),
		.push      (push),
		.state_next(state_next)
	);

	lccp_result_fifo #(
		.DEPTH(FIFO_DEPTH)
	) u_result_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push_en(consume),
		.push   (push),
		.room   (room),
		.results(results)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.coefficient <= items.coefficient;
			item_s1.in_byte     <= items.in_byte;
			item_s1.end_of_poly <= items.end_of_poly;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q  <= LCCP_BITS_RESET;
			dir_q   <= LCCP_DIR_COMPRESS;
			state_q <= '0;
		end else if (cfg_wr_en) begin
			case (lccp_reg_t'(cfg_index))
				LCCP_REG_COMPRESS_BITS: begin
					bits_q <= cfg_data[LCCP_BITS_W-1:0];
				end
				LCCP_REG_DIRECTION: begin
					dir_q <= lccp_dir_t'(cfg_data[0]);
				end
				default: begin
					bits_q <= bits_q;
				end
			endcase
			state_q <= '0;
		end else if (consume) begin
			state_q <= state_next;
		end
	end

endmodule

// File: rtl/lccp_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the compress/pack unit, bound to the top level.
// Depends on lattice_coeff_compress_pack_unit.
module lccp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [11:0] out_value,
	input logic        out_last
);

	assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result valid during reset");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("stalled result withdrawn");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_value) && $stable(out_last))
		else $error("stalled result changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_value <= 12'd3328)
		else $error("result value out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input held off with an empty result queue");

endmodule

bind lattice_coeff_compress_pack_unit lccp_checker u_lccp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_ready (items.ready),
	.out_valid(results.valid),
	.out_ready(results.ready),
	.out_value(results.out_value),
	.out_last (results.last)
);

// File: verif/lccp_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the lattice coefficient compress/pack unit: watches the item, result
// and register-write ports, predicts every result and compares it field by field.
// Depends on lccp_pkg and the channel interfaces in lccp_if.
module lccp_result_checker import lccp_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [LCCP_CFG_IDX_W-1:0]  cfg_index,
	input  logic [LCCP_CFG_DATA_W-1:0] cfg_data,
	lccp_in_if                         items,
	lccp_out_if                        results,
	output int                         mismatches,
	output int                         pending
);
	localparam int unsigned Q    = 3329;
	localparam int unsigned HALF = 1664;

	logic [LCCP_BITS_W-1:0] bits_reg;
	lccp_dir_t              dir_reg;
	logic [LCCP_ACC_W-1:0]  bit_acc;
	logic [LCCP_CNT_W-1:0]  bit_cnt;
	lccp_result_t           expected_q[$];
	int                     fail_count = 0;

	function automatic int unsigned coeff_width(input logic [LCCP_BITS_W-1:0] bits);
		if (bits < LCCP_BITS_MIN) return 32'(LCCP_BITS_MIN);
		if (bits > LCCP_BITS_MAX) return 32'(LCCP_BITS_MAX);
		return 32'(bits);
	endfunction

	function automatic int unsigned round_coeff(input logic signed [LCCP_COEF_W-1:0] c,
			input int unsigned d);
		int          s;
		int unsigned shifted;
		s = c;
		shifted = s + Q;
		if (s < 0) shifted += Q;
		return (((shifted << d) + HALF) / Q) & ((32'd1 << d) - 1);
	endfunction

	function automatic logic [LCCP_VALUE_W-1:0] expand_value(input int unsigned t,
			input int unsigned d);
		return LCCP_VALUE_W'((t * Q + (32'd1 << (d - 1))) >> d);
	endfunction

	task automatic note_failure(input string msg);
		if (fail_count < 10) $display("%0t: %s", $time, msg);
		fail_count++;
	endtask

	task automatic absorb_item(input logic signed [LCCP_COEF_W-1:0] coef,
			input logic [LCCP_BYTE_W-1:0] in_b, input logic eop);
		int unsigned  d;
		int           n;
		lccp_result_t made [2];
		d = coeff_width(bits_reg);
		n = 0;
		if (dir_reg == LCCP_DIR_COMPRESS) begin
			bit_acc = bit_acc | (LCCP_ACC_W'(round_coeff(coef, d)) << bit_cnt);
			bit_cnt = bit_cnt + LCCP_CNT_W'(d);
			if (bit_cnt >= LCCP_CNT_W'(8)) begin
				made[n].value = LCCP_VALUE_W'(bit_acc[7:0]);
				made[n].last = 1'b0;
				n++;
				bit_acc = bit_acc >> 8;
				bit_cnt = bit_cnt - LCCP_CNT_W'(8);
			end
			// flush the partial byte, zero padded
			if (eop && bit_cnt != '0) begin
				made[n].value = LCCP_VALUE_W'(bit_acc[7:0]);
				made[n].last = 1'b0;
				n++;
			end
		end else begin
			bit_acc = bit_acc | (LCCP_ACC_W'(in_b) << bit_cnt[2:0]);
			bit_cnt = bit_cnt + LCCP_CNT_W'(8);
			while (n < 2 && 32'(bit_cnt) >= d) begin
				made[n].value = expand_value(32'(bit_acc) & ((32'd1 << d) - 1), d);
				made[n].last = 1'b0;
				n++;
				bit_acc = bit_acc >> d;
				bit_cnt = bit_cnt - LCCP_CNT_W'(d);
			end
		end
		if (eop) begin
			if (n > 0) made[n - 1].last = 1'b1;
			bit_acc = '0;
			bit_cnt = '0;
		end
		for (int i = 0; i < n; i++) expected_q.push_back(made[i]);
	endtask

	task automatic compare_result(input logic [LCCP_VALUE_W-1:0] value, input logic last);
		lccp_result_t want;
		if (expected_q.size() == 0) begin
			note_failure($sformatf("result with none expected: value %0d last %0b",
				value, last));
		end else begin
			want = expected_q.pop_front();
			if (value !== want.value || last !== want.last)
				note_failure($sformatf({"result mismatch: expected value %0d last %0b,",
					" got value %0d last %0b"}, want.value, want.last, value, last));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_reg = LCCP_BITS_RESET;
			dir_reg = LCCP_DIR_COMPRESS;
			bit_acc = '0;
			bit_cnt = '0;
			expected_q.delete();
		end else begin
			if (cfg_wr_en) begin
				if (cfg_index == LCCP_REG_COMPRESS_BITS) bits_reg = cfg_data;
				else dir_reg = lccp_dir_t'(cfg_data[0]);
				bit_acc = '0;
				bit_cnt = '0;
			end
			if (results.valid && results.ready) compare_result(results.out_value, results.last);
			if (items.valid && items.ready)
				absorb_item(items.coefficient, items.in_byte, items.end_of_poly);
		end
		pending <= expected_q.size();
		mismatches <= fail_count;
	end

endmodule

// File: verif/lattice_coeff_compress_pack_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for the lattice coefficient compress/pack unit: drives directed and random
// items under several register settings with random idling, and gives the verdict.
// Depends on lccp_pkg, lccp_if, lccp_result_checker and the unit itself.
module lattice_coeff_compress_pack_unit_tb;
	import lccp_pkg::*;

	localparam int HOLD_OFF_CYCLES = 64;
	localparam int DRAIN_CYCLES    = 6;
	localparam int RAND_PHASES     = 12;
	localparam int PHASE_ITEMS     = 136;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_wr_en;
	logic [LCCP_CFG_IDX_W-1:0]  cfg_index;
	logic [LCCP_CFG_DATA_W-1:0] cfg_data;
	int                         mismatches;
	int                         pending;
	bit                         idle_on;
	bit                         stall_on;
	bit                         hold_off_req;

	lccp_in_if  items();
	lccp_out_if results();

	lattice_coeff_compress_pack_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.items     (items),
		.results   (results)
	);

	lccp_result_checker result_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.items      (items),
		.results    (results),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	// result side: random stall bursts and one long hold-off
	initial begin
		bit held;
		held = 1'b0;
		results.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_off_req && !held) begin
				results.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
				held = 1'b1;
			end else if (stall_on && $urandom_range(0, 5) == 0) begin
				results.ready <= 1'b0;
				repeat ($urandom_range(1, 5) - 1) @(posedge clk);
			end else begin
				results.ready <= 1'b1;
			end
		end
	end

	task automatic send_item(input logic signed [LCCP_COEF_W-1:0] coef,
			input logic [LCCP_BYTE_W-1:0] in_b, input logic eop);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			items.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		items.valid <= 1'b1;
		items.coefficient <= coef;
		items.in_byte <= in_b;
		items.end_of_poly <= eop;
		@(posedge clk);
		while (!items.ready) @(posedge clk);
	endtask

	task automatic send_coeff(input int c, input logic eop);
		send_item(LCCP_COEF_W'(c), LCCP_BYTE_W'($urandom), eop);
	endtask

	task automatic send_byte(input logic [LCCP_BYTE_W-1:0] b, input logic eop);
		send_item(LCCP_COEF_W'($urandom), b, eop);
	endtask

	function automatic logic signed [LCCP_COEF_W-1:0] rand_coeff();
		case ($urandom_range(0, 7))
			0: return LCCP_COEF_W'($urandom);
			1: begin
				case ($urandom_range(0, 3))
					0: return LCCP_COEF_W'(-3329);
					1: return LCCP_COEF_W'(3328);
					2: return LCCP_COEF_W'(-4096);
					default: return LCCP_COEF_W'(4095);
				endcase
			end
			default: return LCCP_COEF_W'(int'($urandom_range(0, 6657)) - 3329);
		endcase
	endfunction

	task automatic send_poly(input int len, input bit closed);
		for (int i = 0; i < len; i++)
			send_item(rand_coeff(), LCCP_BYTE_W'($urandom), closed && (i == len - 1));
	endtask

	task automatic write_config(input logic [LCCP_BITS_W-1:0] bits, input lccp_dir_t dir);
		cfg_wr_en <= 1'b1;
		cfg_index <= LCCP_REG_COMPRESS_BITS;
		cfg_data <= bits;
		@(posedge clk);
		cfg_index <= LCCP_REG_DIRECTION;
		cfg_data <= {2'($urandom_range(0, 3)), dir};
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// drop valid, then wait for the pipeline and the result queue to empty
	task automatic settle();
		items.valid <= 1'b0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		int sent;
		int len;
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= LCCP_REG_COMPRESS_BITS;
		cfg_data <= '0;
		items.valid <= 1'b0;
		items.coefficient <= '0;
		items.in_byte <= '0;
		items.end_of_poly <= 1'b0;
		idle_on = 1'b1;
		stall_on = 1'b1;
		hold_off_req = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: six bits, compress; range extremes and out-of-range values
		send_coeff(-3329, 1'b0);
		send_coeff(3328, 1'b0);
		send_coeff(0, 1'b0);
		send_coeff(-1, 1'b0);
		send_coeff(1664, 1'b0);
		send_coeff(-4096, 1'b0);
		send_coeff(4095, 1'b1);
		settle();

		// width below range; single-item polynomial, then leftover bits cleared by a write
		write_config(LCCP_BITS_W'(0), LCCP_DIR_COMPRESS);
		send_coeff(2000, 1'b1);
		send_coeff(3328, 1'b0);
		send_coeff(-1, 1'b0);
		send_coeff(1665, 1'b0);
		settle();

		// width above range, decompress; leftover bits discarded at end of polynomial
		write_config(LCCP_BITS_W'(7), LCCP_DIR_DECOMPRESS);
		send_byte(8'hff, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'ha5, 1'b0);
		send_byte(8'h3c, 1'b1);
		settle();

		write_config(LCCP_BITS_W'(5), LCCP_DIR_DECOMPRESS);
		send_byte(8'h80, 1'b1);
		send_byte(8'hff, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h7e, 1'b1);
		settle();

		write_config(LCCP_BITS_W'(4), LCCP_DIR_DECOMPRESS);
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b1);
		send_byte(8'h5a, 1'b0);
		settle();

		write_config(LCCP_BITS_W'(6), LCCP_DIR_COMPRESS);
		send_coeff(1, 1'b0);
		send_coeff(3328, 1'b1);
		settle();

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			idle_on = (ph < RAND_PHASES - 2) && ($urandom_range(0, 3) != 0);
			stall_on = (ph < RAND_PHASES - 2) && ($urandom_range(0, 3) != 0);
			write_config(($urandom_range(0, 3) == 0) ? LCCP_BITS_W'($urandom_range(0, 7))
				: LCCP_BITS_W'($urandom_range(4, 6)), lccp_dir_t'($urandom_range(0, 1)));
			if (ph == 1) hold_off_req = 1'b1;
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				len = ($urandom_range(0, 9) == 0) ? 128 : int'($urandom_range(1, 24));
				if (len > PHASE_ITEMS - sent) len = PHASE_ITEMS - sent;
				send_poly(len, $urandom_range(0, 7) != 0);
				sent += len;
			end
			settle();
		end

		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
